FILE: rtl/lpcd_pkg.sv
// lpcd_pkg: shared types and codes for the pinned lru cache directory
// used by lpcd_cell and lru_pinned_cache_directory_top; no dependencies
`default_nettype none

package lpcd_pkg;

    // fixed field widths
    localparam int OPCODE_BITS = 2;
    localparam int STATUS_BITS = 3;
    localparam int CAP_BITS    = 5;

    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

    // request opcodes
    localparam logic [OPCODE_BITS-1:0] OP_GET     = 2'd0;
    localparam logic [OPCODE_BITS-1:0] OP_RELEASE = 2'd1;
    localparam logic [OPCODE_BITS-1:0] OP_PUT     = 2'd2;

    // result status codes
    localparam logic [STATUS_BITS-1:0] ST_HIT       = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_MISS      = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_REFUSED   = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_ABSENT    = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_UNDERFLOW = 3'd4;

    // action applied to the selected cell during the update cycle
    typedef enum logic [2:0] {
        ACT_NONE      = 3'd0,
        ACT_INC       = 3'd1,
        ACT_DEC_MRU   = 3'd2,
        ACT_DIRTY_MRU = 3'd3,
        ACT_FILL      = 3'd4
    } action_t;

    // update command broadcast to every cell
    typedef struct packed {
        logic    en;
        action_t action;
        logic    do_dec;
        logic    fill_dirty;
    } upd_t;

    // control flags of the search token moving down the chain
    typedef struct packed {
        logic valid;
        logic found;
        logic free_have;
        logic vict_have;
        logic vict_dirty;
    } tok_t;

endpackage

`default_nettype wire

FILE: rtl/lru_pinned_cache_directory_top.sv
// lru_pinned_cache_directory_top: request control, decision and the row of cells
// depends on lpcd_pkg and lpcd_cell
`default_nettype none

// A request (opcode, key_tag) is taken when start is high and busy is low.
// The lookup runs as a token through the row of ENTRIES cells, one cell per
// cycle, gathering the hit, the first free slot, the occupancy and the least
// recent unpinned entry; as the token leaves the last cell, the update is
// applied to all cells at once. The result appears on the result ports with
// done high for exactly one cycle, and cannot be stalled. busy drops in the
// cycle that done is high; the cell chain length sets how long a request
// takes. The user must write capacity through cfg_valid/cfg_data (cfg_ready
// is always high) only while the block is idle; the block does not enforce it.

module lru_pinned_cache_directory_top #(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 32,
    parameter int COUNT_BITS = 8
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 start,
    output logic                                busy,
    input  wire  [lpcd_pkg::OPCODE_BITS-1:0]    opcode,
    input  wire  [KEY_BITS-1:0]                 key_tag,
    output logic                                done,
    output logic [lpcd_pkg::STATUS_BITS-1:0]    status,
    output logic [$clog2(ENTRIES)-1:0]          slot,
    output logic                                evicted_valid,
    output logic [KEY_BITS-1:0]                 evicted_key,
    output logic                                writeback_needed,
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire  [lpcd_pkg::CAP_BITS-1:0]       cfg_data
);

    localparam int SLOT_BITS = $clog2(ENTRIES);
    localparam int OCC_BITS  = $clog2(ENTRIES + 1);
    localparam int CMP_BITS  = (OCC_BITS > lpcd_pkg::CAP_BITS) ? OCC_BITS : lpcd_pkg::CAP_BITS;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_LAUNCH = 3'b010,
        S_SCAN   = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [lpcd_pkg::CAP_BITS-1:0]    cap_reg;
    logic [lpcd_pkg::OPCODE_BITS-1:0] op_reg;
    logic [KEY_BITS-1:0]              key_reg;
    logic                             accept;

    logic                             done_reg;
    logic [lpcd_pkg::STATUS_BITS-1:0] status_reg, status_next;
    logic [SLOT_BITS-1:0]             slot_reg, slot_next;
    logic                             ev_valid_reg, ev_valid_next;
    logic [KEY_BITS-1:0]              ev_key_reg, ev_key_next;
    logic                             wb_reg, wb_next;

    // token chain, index 0 is the launch point, index ENTRIES the far end
    lpcd_pkg::tok_t        tok       [0:ENTRIES];
    logic [SLOT_BITS-1:0]  hit_idx   [0:ENTRIES];
    logic [SLOT_BITS-1:0]  hit_rank  [0:ENTRIES];
    logic [COUNT_BITS-1:0] hit_cnt   [0:ENTRIES];
    logic [OCC_BITS-1:0]   occ       [0:ENTRIES];
    logic [SLOT_BITS-1:0]  free_idx  [0:ENTRIES];
    logic [SLOT_BITS-1:0]  vict_rank [0:ENTRIES];
    logic [SLOT_BITS-1:0]  vict_idx  [0:ENTRIES];
    logic [KEY_BITS-1:0]   vict_key  [0:ENTRIES];

    lpcd_pkg::upd_t        upd;
    logic [SLOT_BITS-1:0]  upd_sel;
    logic [SLOT_BITS-1:0]  upd_ref_rank;
    logic [SLOT_BITS-1:0]  upd_set_rank;
    logic [COUNT_BITS-1:0] upd_fill_count;

    lpcd_pkg::tok_t        last_tok;
    logic [CMP_BITS-1:0]   cap_w;
    logic [CMP_BITS-1:0]   cap_eff;
    logic                  full;
    logic [SLOT_BITS-1:0]  occ_top;
    logic [SLOT_BITS-1:0]  occ_mru;

    // request handshake
    assign accept    = start && (state_reg == S_IDLE);
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_LAUNCH;
                end
            end
            S_LAUNCH:
            begin
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (last_tok.valid)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // launch token
    always_comb
    begin
        tok[0]           = '0;
        tok[0].valid     = (state_reg == S_LAUNCH);
        hit_idx[0]       = '0;
        hit_rank[0]      = '0;
        hit_cnt[0]       = '0;
        occ[0]           = '0;
        free_idx[0]      = '0;
        vict_rank[0]     = '0;
        vict_idx[0]      = '0;
        vict_key[0]      = '0;
    end

    // row of cells
    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        lpcd_cell #(
            .ENTRIES    (ENTRIES),
            .KEY_BITS   (KEY_BITS),
            .COUNT_BITS (COUNT_BITS),
            .SLOT       (i)
        ) u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .lookup_key     (key_reg),
            .upd            (upd),
            .upd_sel        (upd_sel),
            .upd_ref_rank   (upd_ref_rank),
            .upd_set_rank   (upd_set_rank),
            .upd_fill_count (upd_fill_count),
            .tok_in         (tok[i]),
            .in_hit_idx     (hit_idx[i]),
            .in_hit_rank    (hit_rank[i]),
            .in_hit_cnt     (hit_cnt[i]),
            .in_occ         (occ[i]),
            .in_free_idx    (free_idx[i]),
            .in_vict_rank   (vict_rank[i]),
            .in_vict_idx    (vict_idx[i]),
            .in_vict_key    (vict_key[i]),
            .tok_out        (tok[i+1]),
            .out_hit_idx    (hit_idx[i+1]),
            .out_hit_rank   (hit_rank[i+1]),
            .out_hit_cnt    (hit_cnt[i+1]),
            .out_occ        (occ[i+1]),
            .out_free_idx   (free_idx[i+1]),
            .out_vict_rank  (vict_rank[i+1]),
            .out_vict_idx   (vict_idx[i+1]),
            .out_vict_key   (vict_key[i+1])
        );
    end

    assign last_tok = tok[ENTRIES];

    // effective capacity, clamped to one..ENTRIES
    always_comb
    begin
        cap_w = CMP_BITS'(cap_reg);
        priority if (cap_w == '0)
        begin
            cap_eff = CMP_BITS'(1);
        end
        else if (cap_w > CMP_BITS'(ENTRIES))
        begin
            cap_eff = CMP_BITS'(ENTRIES);
        end
        else
        begin
            cap_eff = cap_w;
        end
        full    = CMP_BITS'(occ[ENTRIES]) >= cap_eff;
        occ_top = occ[ENTRIES][SLOT_BITS-1:0];
        occ_mru = SLOT_BITS'(occ[ENTRIES] - OCC_BITS'(1));
    end

    // decision on the finished token
    always_comb
    begin
        status_next       = lpcd_pkg::ST_ABSENT;
        slot_next         = '0;
        ev_valid_next     = 1'b0;
        ev_key_next       = '0;
        wb_next           = 1'b0;
        upd.en            = last_tok.valid;
        upd.action        = lpcd_pkg::ACT_NONE;
        upd.do_dec        = 1'b0;
        upd.fill_dirty    = (op_reg == lpcd_pkg::OP_PUT);
        upd_sel           = '0;
        upd_ref_rank      = '0;
        upd_set_rank      = '0;
        upd_fill_count    = (op_reg == lpcd_pkg::OP_GET) ? COUNT_BITS'(1) : '0;
        unique case (op_reg)
            lpcd_pkg::OP_RELEASE:
            begin
                if (last_tok.found)
                begin
                    slot_next = hit_idx[ENTRIES];
                    if (hit_cnt[ENTRIES] == '0)
                    begin
                        status_next = lpcd_pkg::ST_UNDERFLOW;
                    end
                    else
                    begin
                        status_next  = lpcd_pkg::ST_HIT;
                        upd.action   = lpcd_pkg::ACT_DEC_MRU;
                        upd.do_dec   = 1'b1;
                        upd_sel      = hit_idx[ENTRIES];
                        upd_ref_rank = hit_rank[ENTRIES];
                        upd_set_rank = occ_mru;
                    end
                end
            end
            lpcd_pkg::OP_GET, lpcd_pkg::OP_PUT:
            begin
                if (last_tok.found)
                begin
                    status_next = lpcd_pkg::ST_HIT;
                    slot_next   = hit_idx[ENTRIES];
                    upd_sel     = hit_idx[ENTRIES];
                    if (op_reg == lpcd_pkg::OP_GET)
                    begin
                        upd.action = lpcd_pkg::ACT_INC;
                    end
                    else
                    begin
                        upd.action   = lpcd_pkg::ACT_DIRTY_MRU;
                        upd.do_dec   = 1'b1;
                        upd_ref_rank = hit_rank[ENTRIES];
                        upd_set_rank = occ_mru;
                    end
                end
                else if (full)
                begin
                    if (last_tok.vict_have)
                    begin
                        // evict the least recent unpinned entry and refill its slot
                        status_next   = lpcd_pkg::ST_MISS;
                        slot_next     = vict_idx[ENTRIES];
                        ev_valid_next = 1'b1;
                        ev_key_next   = vict_key[ENTRIES];
                        wb_next       = last_tok.vict_dirty;
                        upd.action    = lpcd_pkg::ACT_FILL;
                        upd.do_dec    = 1'b1;
                        upd_sel       = vict_idx[ENTRIES];
                        upd_ref_rank  = vict_rank[ENTRIES];
                        upd_set_rank  = occ_mru;
                    end
                    else
                    begin
                        status_next = lpcd_pkg::ST_REFUSED;
                    end
                end
                else
                begin
                    // room left: fill the first free slot
                    status_next  = lpcd_pkg::ST_MISS;
                    slot_next    = free_idx[ENTRIES];
                    upd.action   = lpcd_pkg::ACT_FILL;
                    upd_sel      = free_idx[ENTRIES];
                    upd_set_rank = occ_top;
                end
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cap_reg   <= lpcd_pkg::CAP_RESET;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= last_tok.valid;
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= opcode;
            key_reg <= key_tag;
        end
        if (last_tok.valid)
        begin
            status_reg   <= status_next;
            slot_reg     <= slot_next;
            ev_valid_reg <= ev_valid_next;
            ev_key_reg   <= ev_key_next;
            wb_reg       <= wb_next;
        end
    end

    assign done             = done_reg;
    assign status           = status_reg;
    assign slot             = slot_reg;
    assign evicted_valid    = ev_valid_reg;
    assign evicted_key      = ev_key_reg;
    assign writeback_needed = wb_reg;

`ifndef SYNTHESIS
    // an accepted item keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("busy not raised after accept");

    // the token reaches the end of the row only while scanning
    a_token_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        last_tok.valid |-> (state_reg == S_SCAN))
        else $error("token at chain end outside scan");

    // a result comes out with the block already free
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    // only an insert can evict
    a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (done && evicted_valid) |-> (status == lpcd_pkg::ST_MISS))
        else $error("eviction without insert");

    // write-back flag only goes with an eviction
    a_wb_evict: assert property (@(posedge clk) disable iff (!rst_n)
        (done && writeback_needed) |-> evicted_valid)
        else $error("write-back without eviction");
`endif

endmodule

`default_nettype wire

FILE: rtl/lpcd_cell.sv
// lpcd_cell: one directory entry plus one stage of the search chain
// depends on lpcd_pkg for the token and update command types
`default_nettype none

module lpcd_cell #(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 32,
    parameter int COUNT_BITS = 8,
    parameter int SLOT       = 0
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire        [KEY_BITS-1:0]     lookup_key,
    input  lpcd_pkg::upd_t                upd,
    input  wire        [$clog2(ENTRIES)-1:0] upd_sel,
    input  wire        [$clog2(ENTRIES)-1:0] upd_ref_rank,
    input  wire        [$clog2(ENTRIES)-1:0] upd_set_rank,
    input  wire        [COUNT_BITS-1:0]   upd_fill_count,
    input  lpcd_pkg::tok_t                tok_in,
    input  wire        [$clog2(ENTRIES)-1:0] in_hit_idx,
    input  wire        [$clog2(ENTRIES)-1:0] in_hit_rank,
    input  wire        [COUNT_BITS-1:0]   in_hit_cnt,
    input  wire        [$clog2(ENTRIES+1)-1:0] in_occ,
    input  wire        [$clog2(ENTRIES)-1:0] in_free_idx,
    input  wire        [$clog2(ENTRIES)-1:0] in_vict_rank,
    input  wire        [$clog2(ENTRIES)-1:0] in_vict_idx,
    input  wire        [KEY_BITS-1:0]     in_vict_key,
    output lpcd_pkg::tok_t                tok_out,
    output logic       [$clog2(ENTRIES)-1:0] out_hit_idx,
    output logic       [$clog2(ENTRIES)-1:0] out_hit_rank,
    output logic       [COUNT_BITS-1:0]   out_hit_cnt,
    output logic       [$clog2(ENTRIES+1)-1:0] out_occ,
    output logic       [$clog2(ENTRIES)-1:0] out_free_idx,
    output logic       [$clog2(ENTRIES)-1:0] out_vict_rank,
    output logic       [$clog2(ENTRIES)-1:0] out_vict_idx,
    output logic       [KEY_BITS-1:0]     out_vict_key
);

    localparam int SLOT_BITS = $clog2(ENTRIES);
    localparam int OCC_BITS  = $clog2(ENTRIES + 1);
    localparam logic [SLOT_BITS-1:0] MY_SLOT = SLOT_BITS'(SLOT);

    // entry state
    logic                  valid_reg, valid_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic                  dirty_reg, dirty_next;
    logic [SLOT_BITS-1:0]  rank_reg, rank_next;

    // token stage registers
    lpcd_pkg::tok_t        tok_reg, tok_next;
    logic [SLOT_BITS-1:0]  hit_idx_reg, hit_idx_next;
    logic [SLOT_BITS-1:0]  hit_rank_reg, hit_rank_next;
    logic [COUNT_BITS-1:0] hit_cnt_reg, hit_cnt_next;
    logic [OCC_BITS-1:0]   occ_reg, occ_next;
    logic [SLOT_BITS-1:0]  free_idx_reg, free_idx_next;
    logic [SLOT_BITS-1:0]  vict_rank_reg, vict_rank_next;
    logic [SLOT_BITS-1:0]  vict_idx_reg, vict_idx_next;
    logic [KEY_BITS-1:0]   vict_key_reg, vict_key_next;

    logic own_match;
    logic own_cand;
    logic take_hit;
    logic take_free;
    logic take_vict;
    logic is_sel;
    logic dec_here;

    // local view of this entry against the passing token
    always_comb
    begin
        own_match = valid_reg && (key_reg == lookup_key);
        own_cand  = valid_reg && (cnt_reg == '0);
        take_hit  = own_match && !tok_in.found;
        take_free = !valid_reg && !tok_in.free_have;
        take_vict = own_cand && (!tok_in.vict_have || (rank_reg < in_vict_rank));
    end

    // merge this entry into the token
    always_comb
    begin
        tok_next.valid      = tok_in.valid;
        tok_next.found      = tok_in.found | own_match;
        tok_next.free_have  = tok_in.free_have | !valid_reg;
        tok_next.vict_have  = tok_in.vict_have | own_cand;
        tok_next.vict_dirty = take_vict ? dirty_reg : tok_in.vict_dirty;
        hit_idx_next   = take_hit  ? MY_SLOT  : in_hit_idx;
        hit_rank_next  = take_hit  ? rank_reg : in_hit_rank;
        hit_cnt_next   = take_hit  ? cnt_reg  : in_hit_cnt;
        occ_next       = in_occ + OCC_BITS'(valid_reg);
        free_idx_next  = take_free ? MY_SLOT  : in_free_idx;
        vict_rank_next = take_vict ? rank_reg : in_vict_rank;
        vict_idx_next  = take_vict ? MY_SLOT  : in_vict_idx;
        vict_key_next  = take_vict ? key_reg  : in_vict_key;
    end

    // entry update from the broadcast command
    always_comb
    begin
        is_sel   = upd.en && (upd_sel == MY_SLOT);
        dec_here = upd.en && upd.do_dec && valid_reg && (upd_sel != MY_SLOT) &&
                   (rank_reg > upd_ref_rank);
        valid_next = valid_reg;
        key_next   = key_reg;
        cnt_next   = cnt_reg;
        dirty_next = dirty_reg;
        rank_next  = dec_here ? (rank_reg - SLOT_BITS'(1)) : rank_reg;
        if (is_sel)
        begin
            unique case (upd.action)
                lpcd_pkg::ACT_NONE:
                begin
                end
                lpcd_pkg::ACT_INC:
                begin
                    if (cnt_reg != '1)
                    begin
                        cnt_next = cnt_reg + COUNT_BITS'(1);
                    end
                end
                lpcd_pkg::ACT_DEC_MRU:
                begin
                    cnt_next  = cnt_reg - COUNT_BITS'(1);
                    rank_next = upd_set_rank;
                end
                lpcd_pkg::ACT_DIRTY_MRU:
                begin
                    dirty_next = 1'b1;
                    rank_next  = upd_set_rank;
                end
                lpcd_pkg::ACT_FILL:
                begin
                    valid_next = 1'b1;
                    key_next   = lookup_key;
                    cnt_next   = upd_fill_count;
                    dirty_next = upd.fill_dirty;
                    rank_next  = upd_set_rank;
                end
                default:
                begin
                end
            endcase
        end
    end

    // entry control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
            dirty_reg <= 1'b0;
            rank_reg  <= '0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
            dirty_reg <= dirty_next;
            rank_reg  <= rank_next;
            tok_reg   <= tok_next;
        end
    end

    // key and token payload
    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        hit_idx_reg   <= hit_idx_next;
        hit_rank_reg  <= hit_rank_next;
        hit_cnt_reg   <= hit_cnt_next;
        occ_reg       <= occ_next;
        free_idx_reg  <= free_idx_next;
        vict_rank_reg <= vict_rank_next;
        vict_idx_reg  <= vict_idx_next;
        vict_key_reg  <= vict_key_next;
    end

    assign tok_out       = tok_reg;
    assign out_hit_idx   = hit_idx_reg;
    assign out_hit_rank  = hit_rank_reg;
    assign out_hit_cnt   = hit_cnt_reg;
    assign out_occ       = occ_reg;
    assign out_free_idx  = free_idx_reg;
    assign out_vict_rank = vict_rank_reg;
    assign out_vict_idx  = vict_idx_reg;
    assign out_vict_key  = vict_key_reg;

endmodule

`default_nettype wire

FILE: tb/tb_lru_pinned_cache_directory_top.sv
// testbench for lru_pinned_cache_directory_top: directed and random directory requests,
// each result checked against an in-bench model of the pinned lru directory
// depends on lpcd_pkg and the rtl of lru_pinned_cache_directory_top
module tb_lru_pinned_cache_directory_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES     = 16;
    localparam int KEY_BITS    = 32;
    localparam int COUNT_BITS  = 8;
    localparam int SLOT_BITS   = $clog2(ENTRIES);
    localparam int PIN_MAX     = (1 << COUNT_BITS) - 1;
    localparam int CYCLE_LIMIT = 1000000;

    // opcode the block ignores
    localparam logic [lpcd_pkg::OPCODE_BITS-1:0] OP_NONE = 2'd3;

    typedef struct packed {
        logic [lpcd_pkg::STATUS_BITS-1:0] status;
        logic [SLOT_BITS-1:0]   slot;
        logic                   ev_valid;
        logic [KEY_BITS-1:0]    ev_key;
        logic                   writeback;
    } dir_outcome_t;

    logic                       clk;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    logic [lpcd_pkg::OPCODE_BITS-1:0] opcode;
    logic [KEY_BITS-1:0]        key_tag;
    logic                       done;
    logic [lpcd_pkg::STATUS_BITS-1:0] status;
    logic [SLOT_BITS-1:0]       slot;
    logic                       evicted_valid;
    logic [KEY_BITS-1:0]        evicted_key;
    logic                       writeback_needed;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [lpcd_pkg::CAP_BITS-1:0] cfg_data;

    // directory mirror
    bit                         ent_valid [ENTRIES];
    logic [KEY_BITS-1:0]        ent_key   [ENTRIES];
    int unsigned                ent_pins  [ENTRIES];
    bit                         ent_dirty [ENTRIES];
    int unsigned                ent_rank  [ENTRIES];
    logic [lpcd_pkg::CAP_BITS-1:0] capacity_reg = lpcd_pkg::CAP_RESET;

    dir_outcome_t               outcome_q [$];
    logic [KEY_BITS-1:0]        key_pool  [$];

    int errors = 0;
    int requests_sent = 0;
    int results_seen = 0;
    int status_seen [8];
    int evictions = 0;
    int dirty_evictions = 0;

    lru_pinned_cache_directory_top #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .opcode           (opcode),
        .key_tag          (key_tag),
        .done             (done),
        .status           (status),
        .slot             (slot),
        .evicted_valid    (evicted_valid),
        .evicted_key      (evicted_key),
        .writeback_needed (writeback_needed),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // run-length guard
    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Simulation FAILED");
        $finish;
    end

    // move a slot to most recent among the valid entries
    function automatic void promote_slot(int s, int occ);
        int unsigned old;
        old = ent_rank[s];
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (ent_valid[i] && i != s && ent_rank[i] > old)
                ent_rank[i]--;
        end
        ent_rank[s] = occ - 1;
    endfunction

    // apply one request to the mirror and return the outcome it must give
    function automatic dir_outcome_t predict_lookup(logic [lpcd_pkg::OPCODE_BITS-1:0] op,
                                                    logic [KEY_BITS-1:0] key);
        dir_outcome_t res;
        int occ;
        int cap;
        int hit;
        bit found;
        int target;
        bit have;
        int unsigned best;
        int unsigned old;
        res = '0;
        res.status = lpcd_pkg::ST_ABSENT;
        occ = 0;
        hit = 0;
        found = 0;
        target = 0;
        have = 0;
        best = 0;
        for (int i = 0; i < ENTRIES; i++)
            if (ent_valid[i])
                occ++;
        cap = int'(capacity_reg);
        if (cap < 1)
            cap = 1;
        if (cap > ENTRIES)
            cap = ENTRIES;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (!found && ent_valid[i] && ent_key[i] == key)
            begin
                hit = i;
                found = 1;
            end
        end

        if (op == OP_NONE)
        begin
            res.status = lpcd_pkg::ST_ABSENT;
        end
        else if (op == lpcd_pkg::OP_RELEASE)
        begin
            if (!found)
                res.status = lpcd_pkg::ST_ABSENT;
            else if (ent_pins[hit] == 0)
            begin
                res.status = lpcd_pkg::ST_UNDERFLOW;
                res.slot = hit[SLOT_BITS-1:0];
            end
            else
            begin
                ent_pins[hit]--;
                promote_slot(hit, occ);
                res.status = lpcd_pkg::ST_HIT;
                res.slot = hit[SLOT_BITS-1:0];
            end
        end
        else if (found)
        begin
            if (op == lpcd_pkg::OP_GET)
            begin
                if (ent_pins[hit] < PIN_MAX)
                    ent_pins[hit]++;
            end
            else
            begin
                ent_dirty[hit] = 1;
                promote_slot(hit, occ);
            end
            res.status = lpcd_pkg::ST_HIT;
            res.slot = hit[SLOT_BITS-1:0];
        end
        else
        begin
            // insert: evict the least recent unpinned entry when full
            if (occ >= cap)
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (ent_valid[i] && ent_pins[i] == 0 && (!have || ent_rank[i] < best))
                    begin
                        best = ent_rank[i];
                        target = i;
                        have = 1;
                    end
                end
                if (have)
                begin
                    res.ev_valid = 1'b1;
                    res.ev_key = ent_key[target];
                    res.writeback = ent_dirty[target];
                    old = ent_rank[target];
                    ent_valid[target] = 0;
                    for (int i = 0; i < ENTRIES; i++)
                        if (ent_valid[i] && ent_rank[i] > old)
                            ent_rank[i]--;
                    occ--;
                end
            end
            else
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (!have && !ent_valid[i])
                    begin
                        target = i;
                        have = 1;
                    end
                end
            end
            if (!have)
                res.status = lpcd_pkg::ST_REFUSED;
            else
            begin
                ent_valid[target] = 1;
                ent_key[target] = key;
                ent_pins[target] = (op == lpcd_pkg::OP_GET) ? 1 : 0;
                ent_dirty[target] = (op == lpcd_pkg::OP_PUT);
                ent_rank[target] = occ;
                res.status = lpcd_pkg::ST_MISS;
                res.slot = target[SLOT_BITS-1:0];
            end
        end
        return res;
    endfunction

    // key of a random pinned entry, or the fallback when nothing is pinned
    function automatic logic [KEY_BITS-1:0] pinned_key_or(logic [KEY_BITS-1:0] fallback);
        int n;
        int idx [ENTRIES];
        n = 0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (ent_valid[i] && ent_pins[i] > 0)
            begin
                idx[n] = i;
                n++;
            end
        end
        if (n == 0)
            return fallback;
        return ent_key[idx[$urandom_range(n - 1)]];
    endfunction

    task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // result checker
    always @(posedge clk)
    begin : check_results
        dir_outcome_t want;
        if (rst_n && done)
        begin
            results_seen++;
            if (outcome_q.size() == 0)
            begin
                errors++;
                $display("%0t: result with no item outstanding, expected none, actual status %0d",
                         $time, status);
            end
            else
            begin
                want = outcome_q.pop_front();
                status_seen[want.status]++;
                if (want.ev_valid)
                begin
                    evictions++;
                    if (want.writeback)
                        dirty_evictions++;
                end
                compare_field("status", 64'(want.status), 64'(status));
                compare_field("slot", 64'(want.slot), 64'(slot));
                compare_field("evicted_valid", 64'(want.ev_valid), 64'(evicted_valid));
                compare_field("evicted_key", 64'(want.ev_key), 64'(evicted_key));
                compare_field("writeback_needed", 64'(want.writeback),
                              64'(writeback_needed));
            end
        end
    end

    // one item: hold start until the block takes it, leave start high on return
    task automatic send_request(logic [lpcd_pkg::OPCODE_BITS-1:0] op,
                                logic [KEY_BITS-1:0] key);
        start <= 1'b1;
        opcode <= op;
        key_tag <= key;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        outcome_q = {outcome_q, predict_lookup(op, key)};
        requests_sent++;
    endtask

    task automatic pause_sender(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // drop start, wait for every result, then let the block go quiet
    task automatic settle();
        start <= 1'b0;
        while (outcome_q.size() != 0)
            @(posedge clk);
        repeat (ENTRIES + 2) @(posedge clk);
    endtask

    task automatic write_capacity(logic [lpcd_pkg::CAP_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        capacity_reg = value;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // hits, misses, dirty puts, releases down to underflow, absent keys, ignored opcode
    task automatic test_basic();
        send_request(lpcd_pkg::OP_GET, 32'h0000_0000);
        send_request(lpcd_pkg::OP_GET, 32'hFFFF_FFFF);
        send_request(lpcd_pkg::OP_GET, 32'h0000_0000);
        send_request(lpcd_pkg::OP_PUT, 32'hFFFF_FFFF);
        send_request(lpcd_pkg::OP_PUT, 32'hA5A5_A5A5);
        send_request(lpcd_pkg::OP_RELEASE, 32'h0000_0000);
        send_request(lpcd_pkg::OP_RELEASE, 32'h0000_0000);
        send_request(lpcd_pkg::OP_RELEASE, 32'h0000_0000);
        send_request(lpcd_pkg::OP_RELEASE, 32'h1234_5678);
        send_request(lpcd_pkg::OP_RELEASE, 32'hA5A5_A5A5);
        send_request(OP_NONE, 32'h0000_0000);
        send_request(OP_NONE, 32'hFFFF_FFFF);
        send_request(lpcd_pkg::OP_GET, 32'hA5A5_A5A5);
        send_request(lpcd_pkg::OP_RELEASE, 32'hA5A5_A5A5);
    endtask

    // pin count runs into its ceiling, then back down to underflow
    task automatic test_pin_saturation();
        settle();
        write_capacity(5'd16);
        repeat (PIN_MAX + 2) send_request(lpcd_pkg::OP_GET, 32'h5A5A_0001);
        repeat (PIN_MAX) send_request(lpcd_pkg::OP_RELEASE, 32'h5A5A_0001);
        send_request(lpcd_pkg::OP_RELEASE, 32'h5A5A_0001);
    endtask

    // capacity below occupancy, everything pinned, zero and oversized capacity
    task automatic test_capacity_edges();
        logic [KEY_BITS-1:0] held [$];
        settle();
        write_capacity(5'd2);
        send_request(lpcd_pkg::OP_GET, 32'h0101_0101);
        send_request(lpcd_pkg::OP_PUT, 32'h0202_0202);
        send_request(lpcd_pkg::OP_GET, 32'h0303_0303);

        // pin every resident entry so the next insert has no victim
        for (int i = 0; i < ENTRIES; i++)
            if (ent_valid[i])
                held = {held, ent_key[i]};
        foreach (held[i])
            send_request(lpcd_pkg::OP_GET, held[i]);
        send_request(lpcd_pkg::OP_GET, 32'h0404_0404);
        send_request(lpcd_pkg::OP_PUT, 32'h0505_0505);
        foreach (held[i])
            send_request(lpcd_pkg::OP_RELEASE, held[i]);
        send_request(lpcd_pkg::OP_RELEASE, 32'h0303_0303);

        settle();
        write_capacity(5'd0);
        send_request(lpcd_pkg::OP_GET, 32'h0606_0606);
        send_request(lpcd_pkg::OP_PUT, 32'h0707_0707);
        send_request(lpcd_pkg::OP_RELEASE, 32'h0606_0606);
        send_request(lpcd_pkg::OP_PUT, 32'h0808_0808);

        // oversized capacity: fill to the array size, then dirty evictions
        settle();
        write_capacity(5'd31);
        for (int i = 0; i < ENTRIES + 3; i++)
            send_request(lpcd_pkg::OP_PUT, 32'hC000_0000 | i);
    endtask

    task automatic run_traffic(int count, int idle_pct);
        logic [lpcd_pkg::OPCODE_BITS-1:0] op;
        logic [KEY_BITS-1:0] key;
        int roll;
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(99);
            if (roll < 35)
                op = lpcd_pkg::OP_GET;
            else if (roll < 70)
                op = lpcd_pkg::OP_RELEASE;
            else if (roll < 95)
                op = lpcd_pkg::OP_PUT;
            else
                op = OP_NONE;
            key = key_pool[$urandom_range(key_pool.size() - 1)];
            if (op == lpcd_pkg::OP_GET && $urandom_range(3) == 0)
                key = $urandom();
            if (op == lpcd_pkg::OP_RELEASE && $urandom_range(3) != 0)
                key = pinned_key_or(key);
            // bursts without gaps between idle stretches
            if (idle_pct > 0 && (i % 40) >= 8 && $urandom_range(99) < idle_pct)
                pause_sender($urandom_range(1, 30));
            send_request(op, key);
        end
    endtask

    task automatic traffic_phase(logic [lpcd_pkg::CAP_BITS-1:0] cap_value, int count,
                                 int idle_pct);
        int eff;
        settle();
        write_capacity(cap_value);
        eff = (cap_value == 0) ? 1 : (cap_value > ENTRIES) ? ENTRIES : int'(cap_value);
        key_pool.delete();
        repeat (eff + $urandom_range(1, 6)) key_pool = {key_pool, KEY_BITS'($urandom())};
        run_traffic(count, idle_pct);
    endtask

    // random traffic over several capacities and sender idle rates
    task automatic test_random_traffic();
        traffic_phase(5'd16, 150, 0);
        traffic_phase(5'd3, 150, 85);
        traffic_phase(5'd1, 150, 6);
        traffic_phase(5'd8, 150, 0);
        traffic_phase(5'($urandom_range(1, 16)), 150, 85);
        traffic_phase(5'($urandom_range(17, 31)), 150, 6);
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        opcode = lpcd_pkg::OP_GET;
        key_tag = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic();
        test_pin_saturation();
        test_capacity_edges();
        test_random_traffic();
        settle();

        $display("%0d items sent, %0d results checked: %0d hits, %0d misses, %0d refused",
                 requests_sent, results_seen, status_seen[lpcd_pkg::ST_HIT],
                 status_seen[lpcd_pkg::ST_MISS], status_seen[lpcd_pkg::ST_REFUSED]);
        $display("%0d absent, %0d underflows, %0d evictions (%0d dirty), %0d mismatches",
                 status_seen[lpcd_pkg::ST_ABSENT], status_seen[lpcd_pkg::ST_UNDERFLOW],
                 evictions, dirty_evictions, errors);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
